// File: sv/trf_pkg.sv
// Shared types and constants for the range frame parser.
package trf_pkg;

   // Frame geometry
   localparam int FRAME_BYTES_DEF = 16;
   localparam int BODY_START      = 2;
   localparam int POS_DIST_LO     = 8;
   localparam int POS_DIST_MID    = 9;
   localparam int POS_DIST_HI     = 10;
   localparam int POS_STATUS      = 11;

   localparam logic [7:0] SYNC_FIRST  = 8'h57;
   localparam logic [7:0] SYNC_SECOND = 8'h00;
   localparam logic [7:0] STATUS_BAD  = 8'hFF;

   // Result kinds
   localparam logic [1:0] KIND_OK    = 2'd0;
   localparam logic [1:0] KIND_RANGE = 2'd1;
   localparam logic [1:0] KIND_FAIL  = 2'd2;

   // Input beat kinds
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Register map
   localparam int         CSR_ADDR_W  = 4;
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_MIN     = 2'd1;
   localparam logic [1:0] REG_MAX     = 2'd2;
   localparam logic [1:0] REG_CHECK   = 2'd3;

   localparam logic [15:0] TIMEOUT_RST = 16'd200;
   localparam logic [15:0] MIN_RST     = 16'd2;
   localparam logic [15:0] MAX_RST     = 16'd1000;
   localparam logic        CHECK_RST   = 1'b1;

   // Divide by ten: floor(x * DIV10_MUL / 2**DIV10_SHIFT) is exact for x < 2**23
   localparam int          MM_W        = 23;
   localparam int          DIV10_SHIFT = 26;
   localparam logic [22:0] DIV10_MUL   = 23'd6710887;
   localparam int          DIST_W      = 20;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } trf_req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [DIST_W-1:0] distance_cm;
   } trf_rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] range_min_cm;
      logic [15:0] range_max_cm;
      logic        range_check_on;
   } trf_cfg_type;

   // Finished frame or timeout, handed from parser to result stage
   typedef struct packed {
      logic        fail;
      logic [23:0] mm;
      logic [7:0]  status;
   } trf_evt_type;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SYNC2 = 2'd1,
      PH_BODY  = 2'd2
   } trf_phase_type;

endpackage

// File: sv/tof_range_frame_parser_top.sv
// Top level of the range frame parser: registers, parser and result stage.
// Path: the closing byte or tick sets evt_valid, then the output register sets rsp_valid.
// Throughput: one req beat per cycle; the event register and the output register
// form a two-deep pipeline, so req stalls only when both are full.
// Reset: synchronous; clears parser state, watchdog and both valid flags,
// and loads the register defaults (timeout 200, min 2, max 1000, check on).
module tof_range_frame_parser_top
   import trf_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  trf_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output trf_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   trf_cfg_type cfg_ff, cfg_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   logic        take;
   logic        evt_valid;
   logic        evt_pop;
   trf_evt_type evt;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_TIMEOUT: cfg_in.timeout_ticks  = csr_pwdata[15:0];
            REG_MIN:     cfg_in.range_min_cm   = csr_pwdata[15:0];
            REG_MAX:     cfg_in.range_max_cm   = csr_pwdata[15:0];
            REG_CHECK:   cfg_in.range_check_on = csr_pwdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks  <= TIMEOUT_RST;
         cfg_ff.range_min_cm   <= MIN_RST;
         cfg_ff.range_max_cm   <= MAX_RST;
         cfg_ff.range_check_on <= CHECK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_idx)
         REG_TIMEOUT: csr_prdata = 32'(cfg_ff.timeout_ticks);
         REG_MIN:     csr_prdata = 32'(cfg_ff.range_min_cm);
         REG_MAX:     csr_prdata = 32'(cfg_ff.range_max_cm);
         REG_CHECK:   csr_prdata = 32'(cfg_ff.range_check_on);
         default:     csr_prdata = '0;
      endcase
   end

   // Input beat taken when the event register is free or drains this cycle
   assign req_ready = !evt_valid || evt_pop;
   assign take      = req_valid && req_ready;

   trf_parser #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .req           (req_data),
      .timeout_ticks (cfg_ff.timeout_ticks),
      .evt_pop       (evt_pop),
      .evt_valid     (evt_valid),
      .evt           (evt)
   );

   trf_result u_result (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (evt_valid),
      .evt       (evt),
      .cfg       (cfg_ff),
      .evt_pop   (evt_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule

// File: sv/trf_parser.sv
// Sync hunt, frame collection, checksum and quiet-time watchdog.
module trf_parser
   import trf_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  trf_req_type req,
   input  logic [15:0] timeout_ticks,
   input  logic        evt_pop,
   output logic        evt_valid,
   output trf_evt_type evt
);

   localparam int IDX_W = $clog2(FRAME_BYTES);

   trf_phase_type    phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic [23:0]      dist_ff, dist_in;
   logic [7:0]       status_ff, status_in;
   logic [15:0]      quiet_ff, quiet_in;
   logic             failed_ff, failed_in;
   logic             evt_valid_ff, evt_valid_in;
   trf_evt_type      evt_ff, evt_in;
   logic             fire;
   logic [7:0]       c;

   assign c = req.rx_byte;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         idx_ff       <= '0;
         sum_ff       <= '0;
         dist_ff      <= '0;
         status_ff    <= '0;
         quiet_ff     <= '0;
         failed_ff    <= 1'b0;
         evt_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         dist_ff      <= dist_in;
         status_ff    <= status_in;
         quiet_ff     <= quiet_in;
         failed_ff    <= failed_in;
         evt_valid_ff <= evt_valid_in;
      end
   end

   // Event payload
   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

   // Next state for one accepted beat
   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      dist_in   = dist_ff;
      status_in = status_ff;
      quiet_in  = quiet_ff;
      failed_in = failed_ff;
      fire      = 1'b0;
      evt_in    = evt_ff;
      if (take) begin
         if (req.action == ACT_TICK) begin
            // watchdog
            if (quiet_ff >= timeout_ticks) begin
               quiet_in = '0;
               if (!failed_ff) begin
                  failed_in  = 1'b1;
                  fire       = 1'b1;
                  evt_in     = '0;
                  evt_in.fail = 1'b1;
               end
            end else begin
               quiet_in = quiet_ff + 16'd1;
            end
         end else begin
            unique case (phase_ff)
               PH_SYNC2: begin
                  if (c == SYNC_SECOND) begin
                     phase_in  = PH_BODY;
                     idx_in    = IDX_W'(BODY_START);
                     sum_in    = SYNC_FIRST + SYNC_SECOND;
                     dist_in   = '0;
                     status_in = '0;
                  end else if (c != SYNC_FIRST) begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_BODY: begin
                  if (idx_ff >= IDX_W'(FRAME_BYTES - 1)) begin
                     // checksum byte closes the frame
                     phase_in = PH_HUNT;
                     idx_in   = '0;
                     if (c == sum_ff) begin
                        quiet_in   = '0;
                        failed_in  = 1'b0;
                        fire       = 1'b1;
                        evt_in.fail   = 1'b0;
                        evt_in.mm     = dist_ff;
                        evt_in.status = status_ff;
                     end
                  end else begin
                     if (idx_ff == IDX_W'(POS_DIST_LO)) dist_in[7:0] = c;
                     else if (idx_ff == IDX_W'(POS_DIST_MID)) dist_in[15:8] = c;
                     else if (idx_ff == IDX_W'(POS_DIST_HI)) dist_in[23:16] = c;
                     else if (idx_ff == IDX_W'(POS_STATUS)) status_in = c;
                     sum_in = sum_ff + c;
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
               default: begin
                  phase_in = (c == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
               end
            endcase
         end
      end
      // event holding register
      if (fire)         evt_valid_in = 1'b1;
      else if (evt_pop) evt_valid_in = 1'b0;
      else              evt_valid_in = evt_valid_ff;
   end

   assign evt_valid = evt_valid_ff;
   assign evt       = evt_ff;

endmodule

// File: sv/trf_result.sv
// Range check, mm to cm conversion and the result output register.
module trf_result
   import trf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        evt_valid,
   input  trf_evt_type evt,
   input  trf_cfg_type cfg,
   output logic        evt_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output trf_rsp_type rsp
);

   logic              rsp_valid_ff, rsp_valid_in;
   trf_rsp_type       rsp_ff, rsp_in;
   logic [23:0]       min_mm, max_mm;
   logic              bad;
   logic [2*MM_W-1:0] prod;

   assign min_mm = 24'(cfg.range_min_cm) * 24'd10;
   assign max_mm = 24'(cfg.range_max_cm) * 24'd10;
   assign prod   = (2*MM_W)'(evt.mm[MM_W-1:0]) * (2*MM_W)'(DIV10_MUL);

   // Out of range: negative, outside limits (when the check is on), or bad status
   always_comb begin
      bad = 1'b0;
      if (evt.mm[23])
         bad = 1'b1;
      else if (cfg.range_check_on && (evt.mm < min_mm || evt.mm > max_mm))
         bad = 1'b1;
      else if (evt.status == STATUS_BAD)
         bad = 1'b1;
   end

   assign evt_pop = evt_valid && (!rsp_valid_ff || rsp_ready);

   // Next result beat
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (evt_pop) begin
         rsp_valid_in = 1'b1;
         if (evt.fail) begin
            rsp_in.result_kind = KIND_FAIL;
            rsp_in.distance_cm = '0;
         end else if (bad) begin
            rsp_in.result_kind = KIND_RANGE;
            rsp_in.distance_cm = '0;
         end else begin
            rsp_in.result_kind = KIND_OK;
            rsp_in.distance_cm = prod[DIV10_SHIFT +: DIST_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
